// ===== sv/atfb_pkg.sv =====
package atfb_pkg;

  localparam int INT_DIGITS_DEF    = 10;
  localparam int A_FRAC_DIGITS_DEF = 3;

  // Decimal digits that any 32-bit value can need.
  localparam int U32_DIGITS = 10;
  localparam int U32_W      = 32;
  localparam int A_MILLI_W  = 10;
  localparam int CNT_W      = 6;

  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE = '0;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_EMIT,
    OP_JSO,
    OP_CONV,
    OP_DIGITS
  } op_e;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_STATE,
    SRC_TENTH,
    SRC_SUM_HI,
    SRC_SUM_LO,
    SRC_F_INT,
    SRC_A_INT,
    SRC_A_FRAC
  } src_e;

  typedef struct packed {
    op_e        op;
    src_e       src;
    logic [7:0] lit;
    logic       sum_en;
    logic       last;
    step_t      target;
  } uword_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    int          i;
    p = 64'd1;
    for (i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'b0000, nib};
    end else begin
      r = CH_A + {4'b0000, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== sv/atfb_ucode_rom.sv =====
module atfb_ucode_rom (
  input  atfb_pkg::step_t  step_i,
  output atfb_pkg::uword_t uw_o
);
  import atfb_pkg::*;

  // Entry point of the checksum trailer, shared by both frame kinds.
  localparam step_t STEP_CKSUM = step_t'(14);

  function automatic uword_t uw(input op_e op, input src_e src, input logic [7:0] lit,
                                input logic sum_en, input logic last, input step_t target);
    uword_t w;
    w.op     = op;
    w.src    = src;
    w.lit    = lit;
    w.sum_en = sum_en;
    w.last   = last;
    w.target = target;
    return w;
  endfunction

  always_comb begin
    case (step_i)
      5'd0:    uw_o = uw(OP_IDLE,   SRC_LIT,    8'h00,   1'b0, 1'b0, STEP_IDLE);
      5'd1:    uw_o = uw(OP_EMIT,   SRC_LIT,    CH_STX,  1'b0, 1'b0, STEP_IDLE);
      5'd2:    uw_o = uw(OP_EMIT,   SRC_STATE,  8'h00,   1'b1, 1'b0, STEP_IDLE);
      5'd3:    uw_o = uw(OP_JSO,    SRC_LIT,    8'h00,   1'b0, 1'b0, STEP_CKSUM);
      5'd4:    uw_o = uw(OP_CONV,   SRC_F_INT,  8'h00,   1'b0, 1'b0, STEP_IDLE);
      5'd5:    uw_o = uw(OP_DIGITS, SRC_F_INT,  8'h00,   1'b1, 1'b0, STEP_IDLE);
      5'd6:    uw_o = uw(OP_EMIT,   SRC_LIT,    CH_DOT,  1'b1, 1'b0, STEP_IDLE);
      5'd7:    uw_o = uw(OP_EMIT,   SRC_TENTH,  8'h00,   1'b1, 1'b0, STEP_IDLE);
      5'd8:    uw_o = uw(OP_EMIT,   SRC_LIT,    CH_SEMI, 1'b1, 1'b0, STEP_IDLE);
      5'd9:    uw_o = uw(OP_CONV,   SRC_A_INT,  8'h00,   1'b0, 1'b0, STEP_IDLE);
      5'd10:   uw_o = uw(OP_DIGITS, SRC_A_INT,  8'h00,   1'b1, 1'b0, STEP_IDLE);
      5'd11:   uw_o = uw(OP_EMIT,   SRC_LIT,    CH_DOT,  1'b1, 1'b0, STEP_IDLE);
      5'd12:   uw_o = uw(OP_CONV,   SRC_A_FRAC, 8'h00,   1'b0, 1'b0, STEP_IDLE);
      5'd13:   uw_o = uw(OP_DIGITS, SRC_A_FRAC, 8'h00,   1'b1, 1'b0, STEP_IDLE);
      5'd14:   uw_o = uw(OP_EMIT,   SRC_SUM_HI, 8'h00,   1'b0, 1'b0, STEP_IDLE);
      5'd15:   uw_o = uw(OP_EMIT,   SRC_SUM_LO, 8'h00,   1'b0, 1'b0, STEP_IDLE);
      5'd16:   uw_o = uw(OP_EMIT,   SRC_LIT,    CH_ETX,  1'b0, 1'b0, STEP_IDLE);
      5'd17:   uw_o = uw(OP_EMIT,   SRC_LIT,    CH_LF,   1'b0, 1'b1, STEP_IDLE);
      default: uw_o = uw(OP_IDLE,   SRC_LIT,    8'h00,   1'b0, 1'b0, STEP_IDLE);
    endcase
  end

endmodule

// ===== sv/atfb_bcd_conv.sv =====
module atfb_bcd_conv #(
  parameter int NDIG = atfb_pkg::U32_DIGITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [atfb_pkg::U32_W-1:0]    value_i,
  input  logic [atfb_pkg::CNT_W-1:0]    nbits_i,
  output logic                          busy_o,
  output logic [NDIG*4-1:0]             bcd_o
);
  import atfb_pkg::*;

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [U32_W-1:0]    sh_q;
  logic [NDIG*4-1:0]   bcd_q;
  logic [NDIG*4-1:0]   adj;

  // Shift-and-add-three: every digit of five or more is corrected before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[U32_W-2:0], 1'b0};
      bcd_q <= {adj[NDIG*4-2:0], sh_q[U32_W-1]};
    end
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== sv/ascii_telemetry_frame_builder.sv =====
// ASCII telemetry frame builder.
//
// The slave channel takes one record request per frame: tuser carries the
// request kind (state only, or state plus two measured values) and tdata the
// state byte and the split integer and fraction parts of both values. The
// master channel delivers the frame one byte per transfer, STX first and LF
// last, with tlast set on the LF byte.
//
// A state-only frame is six bytes; the sequencer is back on its idle step, and
// ready for the next request, in the same cycle that its LF byte is presented.
// A data-pair frame's length depends on the digit counts of the two integers.
// Each of the three decimal conversions runs on one shared shift-and-add-three
// unit at one bit a cycle, over all 32 bits of each integer and the 10 bits of
// the fraction. The slave side is ready only while the sequencer sits on its
// idle step.
//
// Reset clears the step counter and the output valid flag; the block then
// waits for a request. When the receiver stalls, the byte sits in the output
// register and the next byte-emitting step holds until the byte is taken.
module ascii_telemetry_frame_builder #(
  parameter int INT_DIGITS    = atfb_pkg::INT_DIGITS_DEF,
  parameter int A_FRAC_DIGITS = atfb_pkg::A_FRAC_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // state_code [7:0], f_int [39:8], f_tenth [43:40], a_int [75:44],
  // a_milli [85:76], zero fill [87:86]
  input  logic [87:0] s_axis_tdata_i,
  // req_type [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tx_byte [7:0]
  output logic [7:0]  m_axis_tdata_o,
  // last_byte
  output logic        m_axis_tlast_o
);
  import atfb_pkg::*;

  // An integer never needs more digits than a 32-bit value can have, and the
  // shared converter must hold the wider of the integer and fraction fields.
  localparam int ND_INT = (INT_DIGITS < U32_DIGITS) ? INT_DIGITS : U32_DIGITS;
  localparam int NDIG   = (ND_INT > A_FRAC_DIGITS) ? ND_INT : A_FRAC_DIGITS;
  localparam int DIGW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  localparam logic [63:0]     INT_LIM  = pow10(INT_DIGITS) - 64'd1;
  localparam logic [63:0]     FRAC_LIM = pow10(A_FRAC_DIGITS) - 64'd1;
  localparam logic [DIGW-1:0] FRAC_TOP = DIGW'(A_FRAC_DIGITS - 1);

  // Captured request, already saturated to what the frame can print.
  logic                 req_q;
  logic [7:0]           state_q;
  logic [U32_W-1:0]     f_int_q;
  logic [3:0]           ften_q;
  logic [U32_W-1:0]     a_int_q;
  logic [A_MILLI_W-1:0] afr_q;

  logic [U32_W-1:0]     f_int_in;
  logic [3:0]           ften_in;
  logic [U32_W-1:0]     a_int_in;
  logic [A_MILLI_W-1:0] afr_in;

  // Sequencer and datapath control.
  step_t            step_q, step_d;
  logic [DIGW-1:0]  ptr_q, ptr_d;
  logic [7:0]       sum_q, sum_d;
  logic             started_q, started_d;
  logic             m_valid_q, m_valid_d;
  logic [7:0]       m_data_q;
  logic             m_last_q;

  uword_t           uw;
  logic             load;
  logic             out_free;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;

  logic             cv_start;
  logic             cv_busy;
  logic [U32_W-1:0] cv_value;
  logic [CNT_W-1:0] cv_nbits;
  logic [NDIG*4-1:0] cv_bcd;
  logic [DIGW-1:0]  msd;
  logic [3:0]       digit;

  atfb_ucode_rom u_rom (
    .step_i (step_q),
    .uw_o   (uw)
  );

  atfb_bcd_conv #(
    .NDIG (NDIG)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cv_start),
    .value_i (cv_value),
    .nbits_i (cv_nbits),
    .busy_o  (cv_busy),
    .bcd_o   (cv_bcd)
  );

  // Saturation of the incoming fields happens once, on capture.
  always_comb begin
    f_int_in = s_axis_tdata_i[39:8];
    a_int_in = s_axis_tdata_i[75:44];
    ften_in  = s_axis_tdata_i[43:40];
    afr_in   = s_axis_tdata_i[85:76];
    if ({32'd0, f_int_in} > INT_LIM) begin
      f_int_in = INT_LIM[U32_W-1:0];
    end
    if ({32'd0, a_int_in} > INT_LIM) begin
      a_int_in = INT_LIM[U32_W-1:0];
    end
    if (ften_in > 4'd9) begin
      ften_in = 4'd9;
    end
    if ({54'd0, afr_in} > FRAC_LIM) begin
      afr_in = FRAC_LIM[A_MILLI_W-1:0];
    end
  end

  // The fraction is left-aligned so that the converter shifts out its bits first.
  always_comb begin
    case (uw.src)
      SRC_A_INT: begin
        cv_value = a_int_q;
        cv_nbits = CNT_W'(U32_W);
      end
      SRC_A_FRAC: begin
        cv_value = {afr_q, {(U32_W-A_MILLI_W){1'b0}}};
        cv_nbits = CNT_W'(A_MILLI_W);
      end
      default: begin
        cv_value = f_int_q;
        cv_nbits = CNT_W'(U32_W);
      end
    endcase
  end

  // Most significant non-zero digit; a zero value prints as a single '0'.
  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (cv_bcd[i*4 +: 4] != 4'd0) begin
        msd = DIGW'(i);
      end
    end
  end

  assign digit    = cv_bcd[ptr_q*4 +: 4];
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    step_d    = step_q;
    ptr_d     = ptr_q;
    sum_d     = sum_q;
    started_d = started_q;
    load      = 1'b0;
    emit      = 1'b0;
    emit_byte = uw.lit;
    emit_last = 1'b0;
    cv_start  = 1'b0;
    case (uw.op)
      OP_IDLE: begin
        if (s_axis_tvalid_i) begin
          load   = 1'b1;
          sum_d  = '0;
          step_d = step_q + step_t'(1);
        end
      end
      OP_EMIT: begin
        case (uw.src)
          SRC_STATE:  emit_byte = state_q;
          SRC_TENTH:  emit_byte = CH_ZERO + {4'b0000, ften_q};
          SRC_SUM_HI: emit_byte = hex_char(sum_q[7:4]);
          SRC_SUM_LO: emit_byte = hex_char(sum_q[3:0]);
          default:    emit_byte = uw.lit;
        endcase
        if (out_free) begin
          emit      = 1'b1;
          emit_last = uw.last;
          if (uw.sum_en) begin
            sum_d = sum_q + emit_byte;
          end
          step_d = uw.last ? STEP_IDLE : step_q + step_t'(1);
        end
      end
      OP_JSO: begin
        step_d = req_q ? step_q + step_t'(1) : uw.target;
      end
      OP_CONV: begin
        // The step first kicks the converter, then waits for it to finish.
        if (!started_q) begin
          cv_start  = 1'b1;
          started_d = 1'b1;
        end else if (!cv_busy) begin
          started_d = 1'b0;
          ptr_d     = (uw.src == SRC_A_FRAC) ? FRAC_TOP : msd;
          step_d    = step_q + step_t'(1);
        end
      end
      OP_DIGITS: begin
        emit_byte = CH_ZERO + {4'b0000, digit};
        if (out_free) begin
          emit  = 1'b1;
          sum_d = sum_q + emit_byte;
          if (ptr_q == '0) begin
            step_d = step_q + step_t'(1);
          end else begin
            ptr_d = ptr_q - DIGW'(1);
          end
        end
      end
      default: begin
        step_d = STEP_IDLE;
      end
    endcase

    if (emit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_IDLE;
      ptr_q     <= '0;
      sum_q     <= '0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      ptr_q     <= ptr_d;
      sum_q     <= sum_d;
      started_q <= started_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q   <= s_axis_tuser_i;
      state_q <= s_axis_tdata_i[7:0];
      f_int_q <= f_int_in;
      ften_q  <= ften_in;
      a_int_q <= a_int_in;
      afr_q   <= afr_in;
    end
    if (emit) begin
      m_data_q <= emit_byte;
      m_last_q <= emit_last;
    end
  end

  assign s_axis_tready_o = (uw.op == OP_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // The converter is never left running once the program has returned to idle.
  a_idle_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !cv_busy)
    else $error("converter busy while the sequencer is idle");

  // Only the closing LF byte carries the end-of-frame mark.
  a_last_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o == CH_LF))
    else $error("end of frame marked on a byte other than LF");

  // The digit pointer stays within the converter's digits.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_DIGITS) |-> (int'(ptr_q) < NDIG))
    else $error("digit pointer beyond the converted digits");

  // An accepted request always moves the program off its idle step.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("sequencer still idle after accepting a request");

endmodule
